[hw/rtl/pcts_pkg.sv]
// Shared types, constants and CP1252 / UTF-8 helpers for the content text scanner.
`timescale 1ns / 1ps

package pcts_pkg;

   // Saturation limit of the literal-string nesting counter
   localparam int MAX_NEST = 255;
   localparam int NEST_W   = $clog2(MAX_NEST + 1);

   // Records held between the front and the back part
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [7:0] in_byte;
      logic       stream_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
   } rsp_type;

   // One character for the back part: text characters go through CP1252,
   // raw ones (newline, space, escape controls) are sent as they are.
   typedef struct packed {
      logic [7:0] code;
      logic       text;
   } char_type;

   // Everything one input byte produces: one or two characters
   typedef struct packed {
      logic     pair;
      char_type c0;
      char_type c1;
   } rec_type;

   // Front state summary
   typedef struct packed {
      logic mode_top;
      logic nest_zero;
      logic octal_clear;
      logic hex_clear;
      logic text_clear;
      logic look_none;
   } front_stat_type;

   // Code points of CP1252 bytes 0x80..0x9F; undefined bytes map to '?'
   localparam logic [15:0] CP1252_HI [32] = '{
      16'h20AC, 16'h003F, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
      16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h003F, 16'h017D, 16'h003F,
      16'h003F, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
      16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h003F, 16'h017E, 16'h0178
   };

   localparam logic [1:0] LEN_ONE   = 2'd1;
   localparam logic [1:0] LEN_TWO   = 2'd2;
   localparam logic [1:0] LEN_THREE = 2'd3;

   function automatic logic [15:0] code_point(char_type ch);
      logic [15:0] cp;
      if (ch.text && (ch.code[7:5] == 3'b100)) begin
         cp = CP1252_HI[ch.code[4:0]];
      end else begin
         cp = {8'h00, ch.code};
      end
      return cp;
   endfunction

   function automatic logic [1:0] utf8_len(logic [15:0] cp);
      logic [1:0] len;
      if (cp[15:7] == '0) begin
         len = LEN_ONE;
      end else if (cp[15:11] == '0) begin
         len = LEN_TWO;
      end else begin
         len = LEN_THREE;
      end
      return len;
   endfunction

   function automatic logic [7:0] utf8_byte(logic [15:0] cp, logic [1:0] len,
                                            logic [1:0] idx);
      logic [7:0] b;
      b = {2'b10, cp[5:0]};
      if (len == LEN_ONE) begin
         b = cp[7:0];
      end else if (len == LEN_TWO) begin
         if (idx == 2'd0) begin
            b = {3'b110, cp[10:6]};
         end
      end else begin
         if (idx == 2'd0) begin
            b = {4'b1110, cp[15:12]};
         end else if (idx == 2'd1) begin
            b = {2'b10, cp[11:6]};
         end
      end
      return b;
   endfunction

endpackage

[hw/rtl/pcts_front.sv]
// Front part: parses the content stream and produces character records.
`timescale 1ns / 1ps

module pcts_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    take,
   input  pcts_pkg::req_type       req_word,
   output logic                    push_valid,
   output pcts_pkg::rec_type       push_rec,
   output pcts_pkg::front_stat_type stat
);
   import pcts_pkg::*;

   localparam logic [2:0] MODE_TOP = 3'd0;
   localparam logic [2:0] MODE_LIT = 3'd1;
   localparam logic [2:0] MODE_ESC = 3'd2;
   localparam logic [2:0] MODE_OCT = 3'd3;
   localparam logic [2:0] MODE_HEX = 3'd4;

   localparam logic [1:0] LOOK_NONE = 2'd0;
   localparam logic [1:0] LOOK_T    = 2'd1;
   localparam logic [1:0] LOOK_TE   = 2'd2;

   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_QUOTE  = 8'h27;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_UC_T   = 8'h54;
   localparam logic [7:0] CH_UC_E   = 8'h45;
   localparam logic [7:0] CH_UC_D   = 8'h44;
   localparam logic [7:0] CH_LC_D   = 8'h64;
   localparam logic [7:0] CH_UC_J   = 8'h4A;
   localparam logic [7:0] CH_LC_J   = 8'h6A;
   localparam logic [7:0] CH_LC_N   = 8'h6E;
   localparam logic [7:0] CH_LC_R   = 8'h72;
   localparam logic [7:0] CH_LC_T   = 8'h74;
   localparam logic [7:0] CH_LC_B   = 8'h62;
   localparam logic [7:0] CH_LC_F   = 8'h66;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_BS     = 8'h08;
   localparam logic [7:0] CH_FF     = 8'h0C;
   localparam logic [7:0] CH_SPACE  = 8'h20;

   localparam logic [NEST_W-1:0] NEST_MAX = NEST_W'(MAX_NEST);
   localparam logic [NEST_W-1:0] NEST_ONE = NEST_W'(1);

   logic [2:0]        mode_ff,  mode_in;
   logic [NEST_W-1:0] depth_ff, depth_in;
   logic [8:0]        acc_ff,   acc_in;
   logic [1:0]        ocnt_ff,  ocnt_in;
   logic [3:0]        hhi_ff,   hhi_in;
   logic              hvld_ff,  hvld_in;
   logic              seen_ff,  seen_in;
   logic [1:0]        look_ff,  look_in;

   logic [7:0]        c;
   logic              is_oct;
   logic              is_hex;
   logic [3:0]        nib;

   // Literal-string handling of the current byte, shared by two modes
   logic              lit_emit;
   logic [2:0]        lit_mode;
   logic [NEST_W-1:0] lit_depth;

   logic              e0, e1;
   char_type          ch0, ch1;

   assign c      = req_word.in_byte;
   assign is_oct = (c >= 8'h30) && (c <= 8'h37);

   always_comb begin
      is_hex = 1'b1;
      nib    = c[3:0];
      if ((c >= 8'h30) && (c <= 8'h39)) begin
         nib = c[3:0];
      end else if (((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46))) begin
         nib = c[3:0] + 4'd9;
      end else begin
         is_hex = 1'b0;
      end
   end

   always_comb begin
      lit_emit  = 1'b1;
      lit_mode  = MODE_LIT;
      lit_depth = depth_ff;
      if (c == CH_BSLASH) begin
         lit_emit = 1'b0;
         lit_mode = MODE_ESC;
      end else if (c == CH_LPAREN) begin
         if (depth_ff < NEST_MAX) begin
            lit_depth = depth_ff + NEST_ONE;
         end
      end else if (c == CH_RPAREN) begin
         if (depth_ff <= NEST_ONE) begin
            lit_emit  = 1'b0;
            lit_depth = '0;
            lit_mode  = MODE_TOP;
         end else begin
            lit_depth = depth_ff - NEST_ONE;
         end
      end
   end

   always_comb begin
      mode_in  = mode_ff;
      depth_in = depth_ff;
      acc_in   = acc_ff;
      ocnt_in  = ocnt_ff;
      hhi_in   = hhi_ff;
      hvld_in  = hvld_ff;
      seen_in  = seen_ff;
      look_in  = look_ff;
      e0       = 1'b0;
      e1       = 1'b0;
      ch0      = '{code: c, text: 1'b1};
      ch1      = '{code: c, text: 1'b1};

      unique case (mode_ff)
         MODE_LIT: begin
            e0       = lit_emit;
            mode_in  = lit_mode;
            depth_in = lit_depth;
         end
         MODE_ESC: begin
            mode_in = MODE_LIT;
            e0      = 1'b1;
            if (is_oct) begin
               e0      = 1'b0;
               acc_in  = {6'd0, c[2:0]};
               ocnt_in = 2'd1;
               mode_in = MODE_OCT;
            end else if (c == CH_LC_N) begin
               ch0 = '{code: CH_LF, text: 1'b0};
            end else if (c == CH_LC_R) begin
               ch0 = '{code: CH_CR, text: 1'b0};
            end else if (c == CH_LC_T) begin
               ch0 = '{code: CH_TAB, text: 1'b0};
            end else if (c == CH_LC_B) begin
               ch0 = '{code: CH_BS, text: 1'b0};
            end else if (c == CH_LC_F) begin
               ch0 = '{code: CH_FF, text: 1'b0};
            end
         end
         MODE_OCT: begin
            if (is_oct && (ocnt_ff != 2'd3)) begin
               acc_in  = {acc_ff[5:0], c[2:0]};
               ocnt_in = ocnt_ff + 2'd1;
               if (ocnt_ff == 2'd2) begin
                  e0      = 1'b1;
                  ch0     = '{code: acc_in[7:0], text: 1'b1};
                  acc_in  = '0;
                  ocnt_in = '0;
                  mode_in = MODE_LIT;
               end
            end else begin
               // Flush the pending value, then treat the byte as string text
               e0       = 1'b1;
               ch0      = '{code: acc_ff[7:0], text: 1'b1};
               acc_in   = '0;
               ocnt_in  = '0;
               e1       = lit_emit;
               mode_in  = lit_mode;
               depth_in = lit_depth;
            end
         end
         MODE_HEX: begin
            if (c == CH_GT) begin
               hvld_in = 1'b0;
               hhi_in  = '0;
               mode_in = MODE_TOP;
            end else if (is_hex) begin
               if (!hvld_ff) begin
                  hhi_in  = nib;
                  hvld_in = 1'b1;
               end else begin
                  e0      = 1'b1;
                  ch0     = '{code: {hhi_ff, nib}, text: 1'b1};
                  hhi_in  = '0;
                  hvld_in = 1'b0;
               end
            end
         end
         default: begin
            look_in = LOOK_NONE;
            if (look_ff == LOOK_T) begin
               if ((c == CH_STAR) || (c == CH_LC_D) || (c == CH_UC_D)) begin
                  if (seen_ff) begin
                     e0      = 1'b1;
                     ch0     = '{code: CH_LF, text: 1'b0};
                     seen_in = 1'b0;
                  end
               end else if ((c == CH_LC_J) || (c == CH_UC_J) ||
                            (c == CH_QUOTE) || (c == CH_DQUOTE)) begin
                  if (seen_ff) begin
                     e0  = 1'b1;
                     ch0 = '{code: CH_SPACE, text: 1'b0};
                  end
                  seen_in = 1'b0;
               end else if (c == CH_UC_E) begin
                  look_in = LOOK_TE;
               end
            end else if (look_ff == LOOK_TE) begin
               if ((c == CH_UC_T) && seen_ff) begin
                  e0      = 1'b1;
                  ch0     = '{code: CH_LF, text: 1'b0};
                  seen_in = 1'b0;
               end
            end
            if (c == CH_LPAREN) begin
               mode_in  = MODE_LIT;
               depth_in = NEST_ONE;
               seen_in  = 1'b1;
            end else if (c == CH_LT) begin
               mode_in = MODE_HEX;
               hvld_in = 1'b0;
               hhi_in  = '0;
               seen_in = 1'b1;
            end else if (c == CH_UC_T) begin
               look_in = LOOK_T;
            end
         end
      endcase

      // End of stream: flush a pending octal escape, then return to rest
      if (req_word.stream_last) begin
         if (mode_in == MODE_OCT) begin
            e0  = 1'b1;
            ch0 = '{code: acc_in[7:0], text: 1'b1};
         end
         mode_in  = MODE_TOP;
         depth_in = '0;
         acc_in   = '0;
         ocnt_in  = '0;
         hhi_in   = '0;
         hvld_in  = 1'b0;
         seen_in  = 1'b0;
         look_in  = LOOK_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_TOP;
         depth_ff <= '0;
         acc_ff   <= '0;
         ocnt_ff  <= '0;
         hhi_ff   <= '0;
         hvld_ff  <= 1'b0;
         seen_ff  <= 1'b0;
         look_ff  <= LOOK_NONE;
      end else if (take) begin
         mode_ff  <= mode_in;
         depth_ff <= depth_in;
         acc_ff   <= acc_in;
         ocnt_ff  <= ocnt_in;
         hhi_ff   <= hhi_in;
         hvld_ff  <= hvld_in;
         seen_ff  <= seen_in;
         look_ff  <= look_in;
      end
   end

   assign push_valid = take && e0;
   assign push_rec   = '{pair: e1, c0: ch0, c1: ch1};

   assign stat = '{mode_top:    (mode_ff == MODE_TOP),
                   nest_zero:   (depth_ff == '0),
                   octal_clear: (acc_ff == '0) && (ocnt_ff == '0),
                   hex_clear:   (hhi_ff == '0) && !hvld_ff,
                   text_clear:  !seen_ff,
                   look_none:   (look_ff == LOOK_NONE)};

endmodule

[hw/rtl/pcts_queue.sv]
// Short record queue between the front and back parts.
`timescale 1ns / 1ps

module pcts_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  pcts_pkg::rec_type push_rec,
   input  logic              pop,
   output logic              full,
   output logic              head_valid,
   output pcts_pkg::rec_type head_rec
);
   import pcts_pkg::*;

   rec_type           mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff,  count_in;

   localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);
   localparam logic [QCNT_W-1:0] CNT_FULL = QCNT_W'(QUEUE_DEPTH);

   assign full       = (count_ff == CNT_FULL);
   assign head_valid = (count_ff != '0);
   assign head_rec   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[hw/rtl/pcts_back.sv]
// Back part: maps characters to UTF-8 and drives the result register.
`timescale 1ns / 1ps

module pcts_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  pcts_pkg::rec_type head_rec,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pcts_pkg::rsp_type rsp_word
);
   import pcts_pkg::*;

   logic       char_sel_ff, char_sel_in;
   logic [1:0] byte_sel_ff, byte_sel_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_word_ff, rsp_word_in;

   char_type   cur;
   logic [15:0] cp;
   logic [1:0] len;
   logic       load;
   logic       char_done;
   logic       rec_done;

   assign cur       = char_sel_ff ? head_rec.c1 : head_rec.c0;
   assign cp        = code_point(cur);
   assign len       = utf8_len(cp);
   assign char_done = (byte_sel_ff == (len - 2'd1));
   assign rec_done  = char_done && (!head_rec.pair || char_sel_ff);

   assign load = head_valid && (!rsp_valid_ff || rsp_ready);
   assign pop  = load && rec_done;

   always_comb begin
      char_sel_in  = char_sel_ff;
      byte_sel_in  = byte_sel_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = '{out_byte: utf8_byte(cp, len, byte_sel_ff), run_last: rec_done};
         if (char_done) begin
            byte_sel_in = '0;
            char_sel_in = !rec_done;
         end else begin
            byte_sel_in = byte_sel_ff + 2'd1;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         char_sel_ff  <= 1'b0;
         byte_sel_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         char_sel_ff  <= char_sel_in;
         byte_sel_ff  <= byte_sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

[hw/rtl/pdf_content_text_scanner.sv]
// Top level of the content-stream text scanner: front, record queue and UTF-8 back end.
`timescale 1ns / 1ps

// Usage
//   req_*  : one raw content-stream byte per word; stream_last marks the final
//            byte of a stream, which flushes a pending octal escape and returns
//            all parse state to rest.
//   rsp_*  : extracted text as UTF-8, one byte per word; run_last is set on the
//            final byte produced by a given input word. Input words that yield
//            no text produce no response words at all.
// Timing
//   An accepted word is queued and its first byte then goes to the result register.
//   The front parses one input word per cycle while the queue has room; the back
//   end sends one UTF-8 byte per cycle while rsp_ready is high. One input word per
//   cycle is sustained while each yields at most one byte, else the output bytes
//   set the pace (up to 6 per input word). A 4-record queue absorbs short bursts.
// Reset and stalls
//   Synchronous reset empties the queue and clears all parse state. When the
//   receiver holds rsp_ready low the result register holds its word, the queue
//   fills behind it and req_ready drops once the queue is full.
module pdf_content_text_scanner (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pcts_pkg::req_type req_word,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pcts_pkg::rsp_type rsp_word
);
   import pcts_pkg::*;

   logic           take;
   logic           q_push;
   rec_type        q_push_rec;
   logic           q_full;
   logic           q_head_valid;
   rec_type        q_head_rec;
   logic           q_pop;
   front_stat_type front_stat;

   // Accept a word whenever the queue has room; the front never stalls itself
   assign req_ready = !q_full;
   assign take      = req_valid && req_ready;

   // Parse the byte and push the characters it yields
   pcts_front u_front (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .req_word   (req_word),
      .push_valid (q_push),
      .push_rec   (q_push_rec),
      .stat       (front_stat)
   );

   // Hold records until the back end has drained them
   pcts_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_rec   (q_push_rec),
      .pop        (q_pop),
      .full       (q_full),
      .head_valid (q_head_valid),
      .head_rec   (q_head_rec)
   );

   // Expand each character to UTF-8 and advance through the result register
   pcts_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_head_valid),
      .head_rec   (q_head_rec),
      .pop        (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_word   (rsp_word)
   );

`ifndef SYNTHESIS
   // Nothing is pending straight after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !q_head_valid))
      else $error("result or queue not empty after reset");

   // End of stream leaves the parser at rest
   a_stream_end_rest: assert property (@(posedge clock) disable iff (reset)
      (take && req_word.stream_last) |=>
         (front_stat.mode_top && front_stat.nest_zero && front_stat.octal_clear &&
          front_stat.hex_clear && front_stat.text_clear && front_stat.look_none))
      else $error("parse state not at rest after stream end");

   // A word that is not the last of its run is always followed by another
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_word.run_last) |=> rsp_valid)
      else $error("run of result words broken off");
`endif

endmodule
